// ===== hw/rtl/gps_fix_gate_heading_tracker_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef GPS_FIX_GATE_HEADING_TRACKER_MACROS_SVH
`define GPS_FIX_GATE_HEADING_TRACKER_MACROS_SVH

// Same-cycle implication.
`define GFHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GFHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gfht_pkg.sv =====
package gfht_pkg;

   localparam int unsigned EAST_W     = 27;
   localparam int unsigned NORTH_W    = 30;
   localparam int unsigned COV_W      = 31;
   localparam int unsigned LEAST_W    = 28;
   localparam int unsigned LNORTH_W   = 31;
   localparam int unsigned HEAD_W     = 16;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned LIMIT_W    = 17;
   localparam int unsigned TURN_W     = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 17;
   localparam int unsigned DX_W       = 29;
   localparam int unsigned DY_W       = 32;
   localparam int unsigned MUL_W      = 32;
   localparam int unsigned PROD_W     = 64;
   localparam int unsigned ANGLE_W    = 32;

   localparam logic [LIMIT_W-1:0] SIGMA_LIMIT_RST = 17'd100;
   localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RST  = 17'd500;
   localparam logic [LIMIT_W-1:0] MIN_MOVE_RST    = 17'd50;
   localparam logic [TURN_W-1:0]  MAX_TURN_RST    = 16'd8192;

   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned TAB_LEN          = 24;
   localparam int unsigned TAB_IDX_W        = 5;

   localparam logic [ANGLE_W-1:0] ATAN_TAB [TAB_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670675,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [STATUS_W-1:0] {
      ST_COV_REJ  = 2'd0,
      ST_JUMP_REJ = 2'd1,
      ST_ACCEPT   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGMA_LIMIT = 2'd0,
      CSR_JUMP_LIMIT  = 2'd1,
      CSR_MIN_MOVE    = 2'd2,
      CSR_MAX_TURN    = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SQ_SIG,
      BK_COV,
      BK_DIFF,
      BK_SQ_DX,
      BK_SQ_DY,
      BK_SQ_JMP,
      BK_SQ_MIN,
      BK_MOVE,
      BK_ANGLE,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] sigma_limit;
      logic [LIMIT_W-1:0] jump_limit;
      logic [LIMIT_W-1:0] min_move;
      logic [TURN_W-1:0]  max_turn;
   } csr_type;

   typedef struct packed {
      logic [EAST_W-1:0]  east;
      logic [NORTH_W-1:0] north;
      logic               cov_chk;
      logic [COV_W-1:0]   cov_sum;
   } fix_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/gfht_if.sv =====
interface gfht_req_if import gfht_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [EAST_W-1:0]          easting_cm;
   logic [NORTH_W-1:0]         northing_cm;
   logic signed [COV_W-1:0]    cov_east;
   logic signed [COV_W-1:0]    cov_north;
   logic                       cov_known;

   modport source (output valid, easting_cm, northing_cm, cov_east, cov_north, cov_known,
                   input ready);
   modport sink   (input valid, easting_cm, northing_cm, cov_east, cov_north, cov_known,
                   output ready);
endinterface

interface gfht_rsp_if import gfht_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [LEAST_W-1:0]  local_east;
   logic signed [LNORTH_W-1:0] local_north;
   logic signed [HEAD_W-1:0]   heading;
   logic                       heading_valid;

   modport source (output valid, status, local_east, local_north, heading, heading_valid,
                   input ready);
   modport sink   (input valid, status, local_east, local_north, heading, heading_valid,
                   output ready);
endinterface

// ===== hw/rtl/gfht_front.sv =====
module gfht_front import gfht_pkg::*; (
   gfht_req_if.sink         req_bus,
   input  queue_status_type q_status,
   output logic             push,
   output fix_entry_type    push_entry
);

   logic signed [COV_W:0] cov_sum;

   assign cov_sum = (COV_W+1)'(req_bus.cov_east) + (COV_W+1)'(req_bus.cov_north);

   assign req_bus.ready = !q_status.full;
   assign push          = req_bus.valid && !q_status.full;

   // a negative sum never trips the covariance gate
   assign push_entry.east    = req_bus.easting_cm;
   assign push_entry.north   = req_bus.northing_cm;
   assign push_entry.cov_chk = req_bus.cov_known && !cov_sum[COV_W];
   assign push_entry.cov_sum = cov_sum[COV_W-1:0];

endmodule

// ===== hw/rtl/gfht_queue.sv =====
`include "gps_fix_gate_heading_tracker_macros.svh"

module gfht_queue import gfht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fix_entry_type    push_entry,
   input  logic             pop,
   output fix_entry_type    head,
   output queue_status_type status
);

   fix_entry_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_W'(1);
      end
      return r;
   endfunction

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `GFHT_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !status.empty, "pop from empty queue")
   `GFHT_ASSERT_NOW(a_no_push_full, clock, reset, push, !status.full, "push into full queue")

endmodule

// ===== hw/rtl/gfht_cordic.sv =====
module gfht_cordic import gfht_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DX_W-1:0]  x_in,
   input  logic signed [DY_W-1:0]  y_in,
   output logic                    done,
   output logic [HEAD_W-1:0]       angle
);

   localparam int unsigned CW = DY_W + 2;
   localparam int unsigned SW = $clog2(CORDIC_STEPS + 1);

   logic signed [CW-1:0] x_ff, y_ff, x_in_step, y_in_step, xs, ys;
   logic signed [CW-1:0] x0, y0;
   logic [ANGLE_W-1:0]   z_ff, z_in_step, z_round, tab_val;
   logic [SW-1:0]        cnt_ff;
   logic                 busy_ff, done_ff;
   logic [HEAD_W-1:0]    angle_ff;
   logic                 y_pos, last;

   assign x0      = CW'(x_in);
   assign y0      = CW'(y_in);
   assign xs      = x_ff >>> cnt_ff;
   assign ys      = y_ff >>> cnt_ff;
   assign y_pos   = !y_ff[CW-1] && (y_ff != '0);
   assign tab_val = ATAN_TAB[TAB_IDX_W'(cnt_ff)];
   assign last    = (cnt_ff == SW'(CORDIC_STEPS - 1));
   assign z_round = z_in_step + ANGLE_W'(32'h8000);

   always_comb begin
      if (y_pos) begin
         x_in_step = x_ff + ys;
         y_in_step = y_ff - xs;
         z_in_step = z_ff + tab_val;
      end else begin
         x_in_step = x_ff - ys;
         y_in_step = y_ff + xs;
         z_in_step = z_ff - tab_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= (x_in != '0) || (y_in != '0);
            done_ff <= (x_in == '0) && (y_in == '0);
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff   <= '0;
         angle_ff <= '0;
         if (x_in[DX_W-1]) begin
            x_ff <= -x0;
            y_ff <= -y0;
            z_ff <= ANGLE_W'(32'h8000_0000);
         end else begin
            x_ff <= x0;
            y_ff <= y0;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         x_ff   <= x_in_step;
         y_ff   <= y_in_step;
         z_ff   <= z_in_step;
         cnt_ff <= cnt_ff + SW'(1);
         if (last) begin
            angle_ff <= z_round[ANGLE_W-1 -: HEAD_W];
         end
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

// ===== hw/rtl/gfht_back.sv =====
`include "gps_fix_gate_heading_tracker_macros.svh"

module gfht_back import gfht_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  csr_type          csr,
   input  fix_entry_type    head,
   input  queue_status_type q_status,
   output logic             pop,
   gfht_rsp_if.source       rsp_bus
);

   back_state_type             state_ff, state_in;
   fix_entry_type              cur_ff;
   logic [PROD_W-1:0]          p_ff, p_in, d2_ff;
   logic [MUL_W-1:0]           mul_a, mul_b;
   logic                       jrej_ff;
   status_type                 status_ff;
   logic signed [LEAST_W-1:0]  le_ff, le_in;
   logic signed [LNORTH_W-1:0] ln_ff, ln_in;
   logic signed [DX_W-1:0]     dx_ff, dx_in, dx_neg;
   logic signed [DY_W-1:0]     dy_ff, dy_in, dy_neg;
   logic [MUL_W-1:0]           dxm_ff, dym_ff;
   logic [EAST_W-1:0]          origin_east_ff, orig_e;
   logic [NORTH_W-1:0]         origin_north_ff, orig_n;
   logic                       origin_valid_ff;
   logic signed [LEAST_W-1:0]  prev_east_ff;
   logic signed [LNORTH_W-1:0] prev_north_ff;
   logic                       prev_valid_ff;
   logic [HEAD_W-1:0]          heading_ff;
   logic                       heading_ok_ff;
   logic                       cov_reject, move_hit, turn_ok;
   logic                       cordic_start, cordic_done, out_load;
   logic [HEAD_W-1:0]          new_head, head_diff;
   logic [HEAD_W:0]            diff_mag;
   logic                       rsp_valid_ff;
   logic [STATUS_W-1:0]        out_status_ff;
   logic signed [LEAST_W-1:0]  out_le_ff;
   logic signed [LNORTH_W-1:0] out_ln_ff;
   logic [HEAD_W-1:0]          out_head_ff;
   logic                       out_head_ok_ff;

   gfht_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (dx_ff),
      .y_in  (dy_ff),
      .done  (cordic_done),
      .angle (new_head)
   );

   // shared multiplier, result registered every cycle
   assign p_in = mul_a * mul_b;

   assign cov_reject = cur_ff.cov_chk &&
                       ({5'b0, cur_ff.cov_sum} > {p_ff[LIMIT_W*2:0], 1'b0});
   assign move_hit   = (d2_ff >= p_ff);

   assign orig_e = origin_valid_ff ? origin_east_ff  : cur_ff.east;
   assign orig_n = origin_valid_ff ? origin_north_ff : cur_ff.north;
   assign le_in  = $signed({1'b0, cur_ff.east})  - $signed({1'b0, orig_e});
   assign ln_in  = $signed({1'b0, cur_ff.north}) - $signed({1'b0, orig_n});
   assign dx_in  = DX_W'(le_ff) - DX_W'(prev_east_ff);
   assign dy_in  = DY_W'(ln_ff) - DY_W'(prev_north_ff);
   assign dx_neg = -dx_in;
   assign dy_neg = -dy_in;

   assign head_diff = new_head - heading_ff;
   assign diff_mag  = head_diff[HEAD_W-1] ? ((HEAD_W+1)'(1) << HEAD_W) - {1'b0, head_diff}
                                          : {1'b0, head_diff};
   assign turn_ok   = (diff_mag <= {1'b0, csr.max_turn});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (!q_status.empty) state_in = BK_SQ_SIG;
         BK_SQ_SIG: state_in = BK_COV;
         BK_COV: begin
            if (cov_reject || !prev_valid_ff) begin
               state_in = BK_FIN;
            end else begin
               state_in = BK_DIFF;
            end
         end
         BK_DIFF:   state_in = BK_SQ_DX;
         BK_SQ_DX:  state_in = BK_SQ_DY;
         BK_SQ_DY:  state_in = BK_SQ_JMP;
         BK_SQ_JMP: state_in = BK_SQ_MIN;
         BK_SQ_MIN: state_in = BK_MOVE;
         BK_MOVE: begin
            if (!jrej_ff && move_hit) begin
               state_in = BK_ANGLE;
            end else begin
               state_in = BK_FIN;
            end
         end
         BK_ANGLE:  if (cordic_done) state_in = BK_FIN;
         BK_FIN:    if (out_load) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      cordic_start = 1'b0;
      out_load     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         BK_IDLE: pop = !q_status.empty;
         BK_SQ_SIG: begin
            mul_a = MUL_W'(csr.sigma_limit);
            mul_b = MUL_W'(csr.sigma_limit);
         end
         BK_SQ_DX: begin
            mul_a = dxm_ff;
            mul_b = dxm_ff;
         end
         BK_SQ_DY: begin
            mul_a = dym_ff;
            mul_b = dym_ff;
         end
         BK_SQ_JMP: begin
            mul_a = MUL_W'(csr.jump_limit);
            mul_b = MUL_W'(csr.jump_limit);
         end
         BK_SQ_MIN: begin
            mul_a = MUL_W'(csr.min_move);
            mul_b = MUL_W'(csr.min_move);
         end
         BK_MOVE: cordic_start = !jrej_ff && move_hit;
         BK_FIN:  out_load = !rsp_valid_ff || rsp_bus.ready;
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= BK_IDLE;
         origin_valid_ff <= 1'b0;
         prev_valid_ff   <= 1'b0;
         heading_ff      <= '0;
         heading_ok_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= out_load || (rsp_valid_ff && !rsp_bus.ready);
         if (state_ff == BK_COV && !cov_reject) begin
            origin_valid_ff <= 1'b1;
         end
         if (out_load && status_ff == ST_ACCEPT) begin
            prev_valid_ff <= 1'b1;
         end
         if (state_ff == BK_ANGLE && cordic_done) begin
            heading_ok_ff <= 1'b1;
            if (!heading_ok_ff || turn_ok) begin
               heading_ff <= new_head;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      if (pop) begin
         cur_ff <= head;
      end
      case (state_ff)
         BK_COV: begin
            if (cov_reject) begin
               status_ff <= ST_COV_REJ;
               le_ff     <= '0;
               ln_ff     <= '0;
            end else begin
               status_ff <= ST_ACCEPT;
               le_ff     <= le_in;
               ln_ff     <= ln_in;
               if (!origin_valid_ff) begin
                  origin_east_ff  <= cur_ff.east;
                  origin_north_ff <= cur_ff.north;
               end
            end
         end
         BK_DIFF: begin
            dx_ff  <= dx_in;
            dy_ff  <= dy_in;
            dxm_ff <= {{(MUL_W-DX_W+1){1'b0}},
                       (dx_in[DX_W-1] ? dx_neg[DX_W-2:0] : dx_in[DX_W-2:0])};
            dym_ff <= dy_in[DY_W-1] ? dy_neg : dy_in;
         end
         BK_SQ_DY:  d2_ff   <= p_ff;
         BK_SQ_JMP: d2_ff   <= d2_ff + p_ff;
         BK_SQ_MIN: jrej_ff <= (d2_ff > p_ff);
         BK_MOVE:   if (jrej_ff) status_ff <= ST_JUMP_REJ;
         BK_FIN: begin
            if (out_load && status_ff == ST_ACCEPT) begin
               prev_east_ff  <= le_ff;
               prev_north_ff <= ln_ff;
            end
         end
         default: ;
      endcase
      if (out_load) begin
         out_status_ff  <= status_ff;
         out_le_ff      <= le_ff;
         out_ln_ff      <= ln_ff;
         out_head_ff    <= heading_ff;
         out_head_ok_ff <= heading_ok_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = out_status_ff;
   assign rsp_bus.local_east    = out_le_ff;
   assign rsp_bus.local_north   = out_ln_ff;
   assign rsp_bus.heading       = out_head_ff;
   assign rsp_bus.heading_valid = out_head_ok_ff;

   `GFHT_ASSERT_NEXT(a_accept_sets_prev, clock, reset, out_load && status_ff == ST_ACCEPT, prev_valid_ff, "accepted fix left no previous point")
   `GFHT_ASSERT_NEXT(a_angle_sets_heading, clock, reset, state_ff == BK_ANGLE && cordic_done, heading_ok_ff, "new heading not marked valid")
   `GFHT_ASSERT_NOW(a_diff_needs_refs, clock, reset, state_ff == BK_DIFF, origin_valid_ff && prev_valid_ff, "displacement taken without origin or previous point")

endmodule

// ===== hw/rtl/gps_fix_gate_heading_tracker.sv =====
// GNSS fix gate and course-over-ground tracker. Each fix beat on req_bus yields exactly
// one result beat on rsp_bus, in order. Fixes enter a two-deep queue and are worked one at a
// time by a sequencer that squares the sigma, step and move limits and the displacement
// through one shared 32x32 multiplier, then runs an iterative CORDIC atan2. The CORDIC
// iterations are skipped when the step is zero; a fix rejected by covariance, or the first
// accepted one, skips the displacement, gate and heading work; one rejected by the jump test
// or too short to update heading skips the CORDIC. Registers on the csr_ port must be
// written only while no fix is in flight; the block itself does not enforce this.
module gps_fix_gate_heading_tracker import gfht_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gfht_req_if.sink              req_bus,
   gfht_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   csr_type          csr_ff;
   queue_status_type q_status;
   fix_entry_type    push_entry, head;
   logic             push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sigma_limit <= SIGMA_LIMIT_RST;
         csr_ff.jump_limit  <= JUMP_LIMIT_RST;
         csr_ff.min_move    <= MIN_MOVE_RST;
         csr_ff.max_turn    <= MAX_TURN_RST;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_idx))
            CSR_SIGMA_LIMIT: csr_ff.sigma_limit <= csr_wr_data[LIMIT_W-1:0];
            CSR_JUMP_LIMIT:  csr_ff.jump_limit  <= csr_wr_data[LIMIT_W-1:0];
            CSR_MIN_MOVE:    csr_ff.min_move    <= csr_wr_data[LIMIT_W-1:0];
            CSR_MAX_TURN:    csr_ff.max_turn    <= csr_wr_data[TURN_W-1:0];
            default:         csr_ff.max_turn    <= csr_ff.max_turn;
         endcase
      end
   end

   gfht_front u_front (
      .req_bus    (req_bus),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   gfht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   gfht_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== tb/gps_fix_gate_heading_tracker_tb.sv =====
module gps_fix_gate_heading_tracker_tb import gfht_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ANGLE_STEPS = 16;
   localparam longint EAST_MAX    = 2 ** EAST_W - 1;
   localparam longint NORTH_MAX   = 2 ** NORTH_W - 1;
   localparam longint COV_MAX     = 2 ** (COV_W - 1) - 1;
   localparam longint COV_MIN     = -(2 ** (COV_W - 1));
   localparam longint ORG_E       = 1000000;
   localparam longint ORG_N       = 2000000;

   localparam logic [ANGLE_W-1:0] TURN_ANGLES [ANGLE_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670675,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   typedef struct packed {
      logic [EAST_W-1:0]       east;
      logic [NORTH_W-1:0]      north;
      logic signed [COV_W-1:0] cov_e;
      logic signed [COV_W-1:0] cov_n;
      logic                    known;
   } gps_fix_type;

   typedef struct packed {
      status_type                 status;
      logic signed [LEAST_W-1:0]  local_east;
      logic signed [LNORTH_W-1:0] local_north;
      logic signed [HEAD_W-1:0]   heading;
      logic                       heading_valid;
   } fix_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   gfht_req_if req_bus ();
   gfht_rsp_if rsp_bus ();

   gps_fix_gate_heading_tracker #(
      .CORDIC_STEPS(ANGLE_STEPS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_idx    (csr_idx),
      .csr_wr_data(csr_wr_data)
   );

   // tracker model state and registers
   logic [LIMIT_W-1:0] sigma_lim = SIGMA_LIMIT_RST;
   logic [LIMIT_W-1:0] jump_lim  = JUMP_LIMIT_RST;
   logic [LIMIT_W-1:0] move_lim  = MIN_MOVE_RST;
   logic [TURN_W-1:0]  turn_lim  = MAX_TURN_RST;
   logic [EAST_W-1:0]  origin_e  = '0;
   logic [NORTH_W-1:0] origin_n  = '0;
   bit                 origin_ok = 0;
   longint             prev_e    = 0;
   longint             prev_n    = 0;
   bit                 prev_ok   = 0;
   logic [HEAD_W-1:0]  head      = '0;
   bit                 head_ok   = 0;

   gps_fix_type    fixes_to_send[$];
   fix_report_type fix_reports[$];
   gps_fix_type    fix_on_bus;
   fix_report_type oldest_report;
   bit          fix_taken      = 0;
   int          fixes_queued   = 0;
   int          fixes_accepted = 0;
   int          reports_seen   = 0;
   int          mismatches     = 0;
   int          send_idle_pct  = 28;
   int          take_idle_pct  = 28;
   int          stall_asks     = 0;
   int          stall_served   = 0;
   int          stall_left     = 0;
   longint      cur_e, cur_n, step_e, step_n;

   function automatic logic [HEAD_W-1:0] cordic_heading(longint y, longint x);
      longint      xs, ys;
      logic [31:0] z, zr;
      if (x == 0 && y == 0) return '0;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < ANGLE_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys;
            y -= xs;
            z += TURN_ANGLES[i];
         end else begin
            x -= ys;
            y += xs;
            z -= TURN_ANGLES[i];
         end
      end
      zr = z + 32'h0000_8000;
      return zr[31:16];
   endfunction

   function automatic fix_report_type track_fix(gps_fix_type f);
      fix_report_type    r;
      longint            le, ln, dx, dy;
      longint unsigned   d2, j2, m2;
      logic [HEAD_W-1:0] nh, dh;
      int                mag;
      le = 0;
      ln = 0;
      if (f.known && longint'($signed(f.cov_e)) + longint'($signed(f.cov_n)) >
          2 * longint'(sigma_lim) * longint'(sigma_lim)) begin
         r.status = ST_COV_REJ;
      end else begin
         if (!origin_ok) begin
            origin_e  = f.east;
            origin_n  = f.north;
            origin_ok = 1;
         end
         le = longint'(f.east) - longint'(origin_e);
         ln = longint'(f.north) - longint'(origin_n);
         r.status = ST_ACCEPT;
         if (prev_ok) begin
            dx = le - prev_e;
            dy = ln - prev_n;
            d2 = dx * dx + dy * dy;
            j2 = longint'(jump_lim) * longint'(jump_lim);
            m2 = longint'(move_lim) * longint'(move_lim);
            if (d2 > j2) begin
               r.status = ST_JUMP_REJ;
            end else if (d2 >= m2) begin
               nh = cordic_heading(dy, dx);
               if (!head_ok) begin
                  head    = nh;
                  head_ok = 1;
               end else begin
                  dh  = nh - head;
                  mag = $signed(dh);
                  if (mag < 0) mag = -mag;
                  if (mag <= int'(turn_lim)) head = nh;
               end
            end
         end
         if (r.status == ST_ACCEPT) begin
            prev_e  = le;
            prev_n  = ln;
            prev_ok = 1;
         end
      end
      r.local_east    = le[LEAST_W-1:0];
      r.local_north   = ln[LNORTH_W-1:0];
      r.heading       = head;
      r.heading_valid = head_ok;
      return r;
   endfunction

   function automatic longint span(longint lim);
      return longint'($urandom_range(2 * lim, 0)) - lim;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // sender: hold a beat until taken, then offer the next one or idle
   always @(posedge clock) begin
      fix_taken = !reset && req_bus.valid && req_bus.ready;
      if (fix_taken) begin
         fix_reports.insert(fix_reports.size(), track_fix(fix_on_bus));
         fixes_accepted++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || fix_taken) begin
         if (fixes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            fix_on_bus = fixes_to_send.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.easting_cm  <= fix_on_bus.east;
            req_bus.northing_cm <= fix_on_bus.north;
            req_bus.cov_east    <= fix_on_bus.cov_e;
            req_bus.cov_north   <= fix_on_bus.cov_n;
            req_bus.cov_known   <= fix_on_bus.known;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure plus long stalls on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_served != stall_asks) begin
         stall_served = stall_asks;
         stall_left   = 400;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (fix_reports.size() == 0) begin
            $display("%0t: result beat with no fix outstanding, status %0d", $time,
                     rsp_bus.status);
            mismatches++;
         end else begin
            oldest_report = fix_reports.pop_front();
            check_field("status", oldest_report.status, rsp_bus.status);
            check_field("local_east", $signed(oldest_report.local_east),
                        $signed(rsp_bus.local_east));
            check_field("local_north", $signed(oldest_report.local_north),
                        $signed(rsp_bus.local_north));
            check_field("heading", $signed(oldest_report.heading), $signed(rsp_bus.heading));
            check_field("heading_valid", oldest_report.heading_valid, rsp_bus.heading_valid);
            reports_seen++;
         end
      end
   end

   task automatic queue_fix(longint east, longint north, longint ce, longint cn, bit known);
      gps_fix_type f;
      f.east  = east[EAST_W-1:0];
      f.north = north[NORTH_W-1:0];
      f.cov_e = ce[COV_W-1:0];
      f.cov_n = cn[COV_W-1:0];
      f.known = known;
      fixes_to_send.insert(fixes_to_send.size(), f);
      fixes_queued++;
   endtask

   task automatic csr_write(csr_idx_type idx, int unsigned value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_idx     = idx;
      csr_wr_data = value[CSR_DATA_W-1:0];
      case (idx)
         CSR_SIGMA_LIMIT: sigma_lim = value[LIMIT_W-1:0];
         CSR_JUMP_LIMIT:  jump_lim  = value[LIMIT_W-1:0];
         CSR_MIN_MOVE:    move_lim  = value[LIMIT_W-1:0];
         CSR_MAX_TURN:    turn_lim  = value[TURN_W-1:0];
         default:         ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic settle();
      wait (reports_seen == fixes_queued);
   endtask

   // mostly plausible tracks with random content, some bad covariance and wild jumps
   task automatic run_fixes(int count);
      longint reach, wob, cov_span, de, dn;
      int     pick;
      reach    = longint'(jump_lim) * 7 / 10;
      wob      = reach / 8 + 1;
      cov_span = longint'(sigma_lim) * longint'(sigma_lim);
      if (cov_span > COV_MAX) cov_span = COV_MAX;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            if ($urandom_range(1)) begin
               de = step_e + span(wob);
               dn = step_n + span(wob);
            end else begin
               de = span(reach);
               dn = span(reach);
            end
            if (de > reach) de = reach;
            if (de < -reach) de = -reach;
            if (dn > reach) dn = reach;
            if (dn < -reach) dn = -reach;
            if (cur_e + de < 0 || cur_e + de > EAST_MAX) de = -de;
            if (cur_n + dn < 0 || cur_n + dn > NORTH_MAX) dn = -dn;
            cur_e += de;
            cur_n += dn;
            step_e = de;
            step_n = dn;
            queue_fix(cur_e, cur_n, span(cov_span), span(cov_span), $urandom_range(1));
         end else if (pick < 90) begin
            queue_fix(cur_e + span(wob), cur_n + span(wob), span(COV_MAX), span(COV_MAX), 1);
         end else begin
            queue_fix($urandom(), $urandom(), span(COV_MAX), span(COV_MAX),
                      $urandom_range(1));
         end
      end
   endtask

   task automatic fix_phase(int unsigned sig, int unsigned jmp, int unsigned mv,
                            int unsigned trn, int count);
      csr_write(CSR_SIGMA_LIMIT, sig);
      csr_write(CSR_JUMP_LIMIT, jmp);
      csr_write(CSR_MIN_MOVE, mv);
      csr_write(CSR_MAX_TURN, trn);
      run_fixes(count);
      settle();
   endtask

   initial begin
      int unsigned jmp;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_idx             = CSR_SIGMA_LIMIT;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.easting_cm  = '0;
      req_bus.northing_cm = '0;
      req_bus.cov_east    = '0;
      req_bus.cov_north   = '0;
      req_bus.cov_known   = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // covariance reject before any origin, then origin with a negative sum
      queue_fix(ORG_E + 5, ORG_N + 5, 20001, 20001, 1);
      queue_fix(ORG_E, ORG_N, COV_MIN, COV_MAX, 1);
      queue_fix(ORG_E + 300, ORG_N, COV_MAX, COV_MAX, 0);
      queue_fix(ORG_E + 300, ORG_N + 300, 10000, 10000, 1);
      queue_fix(ORG_E + 600, ORG_N + 700, 0, 0, 1);
      queue_fix(ORG_E + 1101, ORG_N + 700, 0, 0, 0);
      queue_fix(ORG_E + 649, ORG_N + 700, 0, 0, 0);
      queue_fix(ORG_E + 699, ORG_N + 700, 0, 0, 0);
      queue_fix(ORG_E + 799, ORG_N + 741, 0, 0, 0);
      queue_fix(0, 0, 0, 0, 0);
      queue_fix(EAST_MAX, NORTH_MAX, COV_MIN, COV_MIN, 1);
      settle();

      // no minimum move, every turn allowed: zero move, half turn and back
      csr_write(CSR_SIGMA_LIMIT, 17'h1FFFF);
      csr_write(CSR_JUMP_LIMIT, 17'h1FFFF);
      csr_write(CSR_MIN_MOVE, 0);
      csr_write(CSR_MAX_TURN, 17'h1FFFF);
      queue_fix(ORG_E + 799, ORG_N + 741, COV_MAX, COV_MAX, 1);
      queue_fix(ORG_E + 499, ORG_N + 741, 0, 0, 1);
      queue_fix(ORG_E + 799, ORG_N + 741, 0, 0, 1);
      settle();

      // zero sigma, turn limit of exactly half a turn
      csr_write(CSR_SIGMA_LIMIT, 0);
      csr_write(CSR_MAX_TURN, 32768);
      csr_write(CSR_MIN_MOVE, 1);
      queue_fix(ORG_E + 799, ORG_N + 741, 1, 0, 1);
      queue_fix(ORG_E + 1099, ORG_N + 741, 0, 0, 1);
      queue_fix(ORG_E + 799, ORG_N + 741, COV_MAX, COV_MAX, 0);
      settle();

      csr_write(CSR_MAX_TURN, 0);
      csr_write(CSR_JUMP_LIMIT, 0);
      queue_fix(ORG_E + 799, ORG_N + 741, 0, 0, 0);
      queue_fix(ORG_E + 800, ORG_N + 741, 0, 0, 0);
      settle();

      cur_e  = ORG_E + 799;
      cur_n  = ORG_N + 741;
      step_e = 0;
      step_n = 0;

      fix_phase(100, 500, 50, 8192, 220);
      fix_phase(0, 0, 0, 0, 150);
      send_idle_pct = 0;
      take_idle_pct = 0;
      fix_phase(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 200);
      send_idle_pct = 28;
      take_idle_pct = 28;
      stall_asks++;
      jmp = $urandom_range(30000, 1000);
      fix_phase($urandom_range(3000), jmp, $urandom_range(jmp / 2), $urandom_range(17'h1FFFF),
                250);
      fix_phase(50, 2000, 0, 32768, 250);
      jmp = $urandom_range(20000, 200);
      fix_phase($urandom_range(1000), jmp, $urandom_range(jmp), $urandom_range(32768), 230);

      repeat (40) @(posedge clock);
      if (mismatches == 0 && fix_reports.size() == 0) begin
         $display("gps_fix_gate_heading_tracker_tb: PASS");
      end else begin
         $display("gps_fix_gate_heading_tracker_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("gps_fix_gate_heading_tracker_tb: FAIL");
      $finish;
   end

endmodule
